// ===== design/lkvc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_pkg
// shared types and constants of the lru key-value cache
// ----------------------------------------------------------------------------
package lkvc_pkg;

   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;
   localparam int CAP_W   = 5;

   localparam logic [CAP_W-1:0]   CAP_RESET  = 5'd16;
   localparam logic [VALUE_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

   // operation codes carried on req_tuser
   localparam logic FUNC_GET = 1'b0;
   localparam logic FUNC_PUT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_UPDATE
   } lkvc_state_type;

   // broadcast command from the controller to every cell
   typedef struct packed {
      logic apply;    // commit the update this cycle
      logic is_put;   // operation is a put
      logic hit_any;  // some cell matched the key
      logic evict;    // store is at or over capacity, oldest entry leaves on insert
   } lkvc_cmd_type;

endpackage

// ===== design/lkvc_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_cell
// one cache slot: key, value, used flag and recency rank
// ----------------------------------------------------------------------------
module lkvc_cell #(
   parameter int RANK_W = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lkvc_pkg::lkvc_cmd_type      cmd,
   input  logic                        sample,
   input  logic [lkvc_pkg::KEY_W-1:0]  in_key,
   input  logic [lkvc_pkg::VALUE_W-1:0] in_value,
   input  logic [RANK_W-1:0]           hit_rank,
   input  logic [RANK_W-1:0]           last_rank,
   input  logic                        free_before,
   output logic                        free_after,
   output logic                        used,
   output logic                        match,
   output logic [lkvc_pkg::VALUE_W-1:0] value,
   output logic [RANK_W-1:0]           rank
);
   import lkvc_pkg::*;

   logic [KEY_W-1:0]   key_ff, key_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic               used_ff, used_in;
   logic [RANK_W-1:0]  rank_ff, rank_in;
   logic               match_ff, match_in;
   logic               victim, free_here, take;

   // oldest used entry leaves when an insert finds the store full
   assign victim     = cmd.evict && used_ff && (rank_ff == last_rank);
   assign free_here  = !used_ff || victim;
   assign take       = free_here && !free_before;
   assign free_after = free_before || free_here;

   assign match_in = sample ? (used_ff && (key_ff == in_key)) : match_ff;

   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      used_in  = used_ff;
      rank_in  = rank_ff;
      if (cmd.apply) begin
         if (cmd.hit_any) begin
            if (match_ff) begin
               rank_in = '0;
               if (cmd.is_put) begin
                  value_in = in_value;
               end
            end else if (used_ff && (rank_ff < hit_rank)) begin
               rank_in = rank_ff + 1'b1;
            end
         end else if (cmd.is_put) begin
            if (take) begin
               used_in  = 1'b1;
               key_in   = in_key;
               value_in = in_value;
               rank_in  = '0;
            end else if (victim) begin
               used_in = 1'b0;
               rank_in = '0;
            end else if (used_ff) begin
               rank_in = rank_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= 1'b0;
         rank_ff  <= '0;
         match_ff <= 1'b0;
      end else begin
         used_ff  <= used_in;
         rank_ff  <= rank_in;
         match_ff <= match_in;
      end
   end

   assign used  = used_ff;
   assign match = match_ff;
   assign value = value_ff;
   assign rank  = rank_ff;

endmodule

// ===== design/lru_key_value_cache_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit
// fully associative key-value cache with least-recently-used replacement
// ----------------------------------------------------------------------------
// A row of ENTRIES identical cells, each holding one key, value, used flag and
// recency rank (0 is most recent). A request has a compare and an update cycle:
// in the compare cycle all cells match the key in parallel and register the
// result; in the update cycle the cells apply the recency change, the insert or
// the eviction, and a get writes its beat to the output register. The next
// request is taken in that same update cycle. A get stalls in the update cycle
// only while the previous result beat still waits on rsp_tready. A put gives
// no result beat. A new key goes into the lowest-numbered free cell, found by a
// free flag rippling along the row. The cache is empty after reset with no
// clearing pass. csr_wr_data sets the capacity (0 acts as 1, above ENTRIES
// acts as ENTRIES); the user must see that it is written only while the block
// is idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module lru_key_value_cache_unit #(
   parameter int ENTRIES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // request: tuser = func; tdata = key [31:0], value [63:32]
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [0:0]                    req_tuser,
   input  logic [63:0]                   req_tdata,
   // response: tuser = hit; tdata = read_value [31:0]
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [0:0]                    rsp_tuser,
   output logic [31:0]                   rsp_tdata,
   // capacity register
   input  logic                          csr_wr_en,
   input  logic [lkvc_pkg::CAP_W-1:0]    csr_wr_data
);
   import lkvc_pkg::*;

   localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   lkvc_state_type state_ff, state_in;

   logic [CAP_W-1:0]   cap_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               func_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [VALUE_W-1:0] value_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_hit_ff;
   logic [VALUE_W-1:0] rsp_value_ff;

   logic               req_fire, update_fire, sample;
   logic [CMP_W-1:0]   cap_ext, eff_cap;
   logic               evict;
   logic [RANK_W-1:0]  last_rank, hit_rank;
   logic [VALUE_W-1:0] hit_value;
   logic               hit_any;
   lkvc_cmd_type       cmd;

   logic [ENTRIES:0]   free_chain;
   logic [ENTRIES-1:0] match_vec, used_vec;
   logic [VALUE_W-1:0] cell_value [ENTRIES];
   logic [RANK_W-1:0]  cell_rank  [ENTRIES];

   // ---------------- capacity ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_wr_en) begin
         cap_ff <= csr_wr_data;
      end
   end

   assign cap_ext = CMP_W'(cap_ff);

   // clamp to 1..ENTRIES
   always_comb begin
      if (cap_ext == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(ENTRIES)) begin
         eff_cap = CMP_W'(ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
   end

   assign evict     = CMP_W'(count_ff) >= eff_cap;
   assign last_rank = RANK_W'(count_ff - CNT_W'(1));

   // ---------------- handshake ----------------
   // a get may commit only when the output register is free or draining
   assign update_fire = (state_ff == ST_UPDATE) &&
                        ((func_ff == FUNC_PUT) || !rsp_valid_ff || rsp_tready);
   assign req_tready  = (state_ff == ST_IDLE) || update_fire;
   assign req_fire    = req_tvalid && req_tready;
   assign sample      = (state_ff == ST_MATCH);

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_MATCH;
         end
         ST_MATCH: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (update_fire) state_in = req_fire ? ST_MATCH : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd.apply   = update_fire;
      cmd.is_put  = (func_ff == FUNC_PUT);
      cmd.hit_any = hit_any;
      cmd.evict   = evict;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // request beat held for the compare and update cycles
   always_ff @(posedge clock) begin
      if (req_fire) begin
         func_ff  <= req_tuser[0];
         key_ff   <= req_tdata[KEY_W-1:0];
         value_ff <= req_tdata[KEY_W+VALUE_W-1:KEY_W];
      end
   end

   // ---------------- cell row ----------------
   assign free_chain[0] = 1'b0;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      lkvc_cell #(
         .RANK_W(RANK_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .sample     (sample),
         .in_key     (key_ff),
         .in_value   (value_ff),
         .hit_rank   (hit_rank),
         .last_rank  (last_rank),
         .free_before(free_chain[i]),
         .free_after (free_chain[i+1]),
         .used       (used_vec[i]),
         .match      (match_vec[i]),
         .value      (cell_value[i]),
         .rank       (cell_rank[i])
      );
   end

   // at most one cell matches, so an or across the row selects it
   always_comb begin
      hit_rank  = '0;
      hit_value = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_rank  = hit_rank  | (match_vec[i] ? cell_rank[i]  : '0);
         hit_value = hit_value | (match_vec[i] ? cell_value[i] : '0);
      end
   end

   assign hit_any = |match_vec;

   // ---------------- fill count ----------------
   always_comb begin
      count_in = count_ff;
      if (update_fire && (func_ff == FUNC_PUT) && !hit_any && !evict) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // ---------------- output register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (update_fire && (func_ff == FUNC_GET)) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (update_fire && (func_ff == FUNC_GET)) begin
         rsp_hit_ff   <= hit_any;
         rsp_value_ff <= hit_any ? hit_value : MISS_VALUE;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tuser[0] = rsp_hit_ff;
   assign rsp_tdata    = rsp_value_ff;

   // ---------------- assertions ----------------
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("more than one cell matched the key");

   a_count_tracks_used: assert property (@(posedge clock) disable iff (reset)
      $countones(used_vec) == int'(count_ff))
      else $error("fill count differs from the number of used cells");

   a_no_accept_in_compare: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MATCH) |-> !req_tready)
      else $error("request taken during the compare cycle");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (update_fire && (func_ff == FUNC_PUT) && !hit_any && !evict)
      |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("insert without eviction did not grow the fill");

   a_free_cell_found: assert property (@(posedge clock) disable iff (reset)
      (update_fire && (func_ff == FUNC_PUT) && !hit_any) |-> free_chain[ENTRIES])
      else $error("insert found no free cell");

endmodule

// ===== tb/sv/lru_key_value_cache_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_checker
// watches the request, response and capacity ports of the lru cache, keeps
// its own copy of the store and compares every lookup beat with the predicted
// hit flag and value
// ----------------------------------------------------------------------------
module lru_key_value_cache_checker #(
   parameter int ENTRIES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [0:0]                    req_tuser,
   input  logic [63:0]                   req_tdata,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [0:0]                    rsp_tuser,
   input  logic [31:0]                   rsp_tdata,
   input  logic                          csr_wr_en,
   input  logic [lkvc_pkg::CAP_W-1:0]    csr_wr_data,
   output int                            lookups_pending,
   output int                            mismatch_count
);
   import lkvc_pkg::*;

   typedef struct {
      logic               hit;
      logic [VALUE_W-1:0] read_value;
   } lookup_result_type;

   lookup_result_type lookups_due [$];

   logic [CAP_W-1:0]   capacity_setting;
   logic [KEY_W-1:0]   slot_key   [ENTRIES];
   logic [VALUE_W-1:0] slot_value [ENTRIES];
   logic               slot_used  [ENTRIES];
   int unsigned        slot_age   [ENTRIES];
   int unsigned        fill;
   int                 fail_tally = 0;

   // slot s becomes the youngest, everything younger than it ages by one
   function automatic void mark_recent(int s);
      int unsigned r;
      r = slot_age[s];
      for (int i = 0; i < ENTRIES; i++)
         if (slot_used[i] && slot_age[i] < r)
            slot_age[i]++;
      slot_age[s] = 0;
   endfunction

   function automatic void store_new(logic [KEY_W-1:0] k, logic [VALUE_W-1:0] v);
      int unsigned limit;
      int          victim;
      int          free_slot;
      limit = (capacity_setting == 0) ? 1 :
              ((capacity_setting > ENTRIES) ? ENTRIES : capacity_setting);
      // at or over capacity: exactly one oldest entry leaves
      if (fill >= limit) begin
         victim = -1;
         for (int i = 0; i < ENTRIES; i++)
            if (slot_used[i] && (victim < 0 || slot_age[i] > slot_age[victim]))
               victim = i;
         if (victim >= 0) begin
            slot_used[victim] = 1'b0;
            slot_age[victim]  = 0;
            if (fill > 0)
               fill--;
         end
      end
      free_slot = -1;
      for (int i = 0; i < ENTRIES; i++)
         if (!slot_used[i] && free_slot < 0)
            free_slot = i;
      if (free_slot < 0)
         return;
      for (int i = 0; i < ENTRIES; i++)
         if (slot_used[i])
            slot_age[i]++;
      slot_used[free_slot]  = 1'b1;
      slot_key[free_slot]   = k;
      slot_value[free_slot] = v;
      slot_age[free_slot]   = 0;
      fill++;
   endfunction

   // apply one request beat, queue the lookup result a get produces
   function automatic void cache_access(logic op, logic [KEY_W-1:0] k,
                                        logic [VALUE_W-1:0] v);
      int                s;
      lookup_result_type r;
      s = -1;
      for (int i = 0; i < ENTRIES; i++)
         if (slot_used[i] && slot_key[i] == k && s < 0)
            s = i;
      if (op == FUNC_GET) begin
         if (s >= 0) begin
            mark_recent(s);
            r.hit        = 1'b1;
            r.read_value = slot_value[s];
         end else begin
            r.hit        = 1'b0;
            r.read_value = MISS_VALUE;
         end
         lookups_due.insert(lookups_due.size(), r);
      end else if (s >= 0) begin
         slot_value[s] = v;
         mark_recent(s);
      end else begin
         store_new(k, v);
      end
   endfunction

   always @(posedge clock) begin : watch
      lookup_result_type due;
      if (reset) begin
         capacity_setting = CAP_RESET;
         fill = 0;
         for (int i = 0; i < ENTRIES; i++) begin
            slot_key[i]   = '0;
            slot_value[i] = '0;
            slot_used[i]  = 1'b0;
            slot_age[i]   = 0;
         end
         lookups_due.delete();
      end else begin
         if (csr_wr_en)
            capacity_setting = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            if (lookups_due.size() == 0) begin
               $display("%0t: unexpected result beat, expected none, actual hit %0b value %h",
                        $time, rsp_tuser[0], rsp_tdata);
               fail_tally++;
            end else begin
               due = lookups_due.pop_front();
               if (rsp_tuser[0] !== due.hit) begin
                  $display("%0t: hit mismatch, expected %0b actual %0b",
                           $time, due.hit, rsp_tuser[0]);
                  fail_tally++;
               end
               if (rsp_tdata !== due.read_value) begin
                  $display("%0t: read_value mismatch, expected %h actual %h",
                           $time, due.read_value, rsp_tdata);
                  fail_tally++;
               end
            end
         end
         if (req_tvalid && req_tready)
            cache_access(req_tuser[0], req_tdata[31:0], req_tdata[63:32]);
      end
      lookups_pending <= lookups_due.size();
      mismatch_count  <= fail_tally;
   end

endmodule

// ===== tb/sv/lru_key_value_cache_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit_tb
// stimulus and verdict for the lru key-value cache
// ----------------------------------------------------------------------------
// A short directed run covers the extreme keys and values, a hit on a stored
// -1, an update, eviction at full capacity and a capacity lowered under the
// fill. Random phases then run gets and puts over a small key pool per
// capacity setting (0, 1, 31 and mid values among them), with random gaps on
// both channels and one long response hold-off that backs up the block. The
// checker beside the block predicts and compares every lookup beat.
// ----------------------------------------------------------------------------
module lru_key_value_cache_unit_tb;
   import lkvc_pkg::*;

   localparam int ENTRIES       = 16;
   localparam int PHASES        = 7;
   localparam int PHASE_ITEMS   = 72;
   localparam int SETTLE_CYCLES = 6;      // a put may still be in its update cycle
   localparam int HOLD_CYCLES   = 120;    // long response hold-off
   localparam int RUN_LIMIT_NS  = 4_000_000;

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_tvalid  = 1'b0;
   logic               req_tready;
   logic [0:0]         req_tuser   = '0;   // func
   logic [63:0]        req_tdata   = '0;   // key [31:0], value [63:32]
   logic               rsp_tvalid;
   logic               rsp_tready  = 1'b1;
   logic [0:0]         rsp_tuser;          // hit
   logic [31:0]        rsp_tdata;          // read_value [31:0]
   logic               csr_wr_en   = 1'b0;
   logic [CAP_W-1:0]   csr_wr_data = '0;

   int                 lookups_pending;
   int                 mismatch_count;

   // idling controls, set per phase by the stimulus
   bit                 source_idle = 1'b1;
   bit                 sink_idle   = 1'b1;
   bit                 long_hold   = 1'b0;
   bit                 hold_served = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   lru_key_value_cache_unit #(
      .ENTRIES     (ENTRIES)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   lru_key_value_cache_checker #(
      .ENTRIES         (ENTRIES)
   ) result_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tuser       (req_tuser),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tuser       (rsp_tuser),
      .rsp_tdata       (rsp_tdata),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .lookups_pending (lookups_pending),
      .mismatch_count  (mismatch_count)
   );

   // offer one request beat, maybe after a short gap, and wait for the handshake;
   // tvalid stays high on return so back-to-back beats need no second assignment
   task automatic send_item(input logic op, input logic [31:0] k, input logic [31:0] v);
      if (source_idle && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {v, k};
      do @(posedge clock); while (!req_tready);
   endtask

   // stop offering, let every lookup beat come back, then give a trailing put
   // time to finish its update
   task automatic wait_until_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (lookups_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // capacity is only written with the cache idle
   task automatic set_capacity(input logic [CAP_W-1:0] c);
      wait_until_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= c;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // response side: random stall bursts, plus one long hold-off counted here
   initial begin : sink
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (long_hold && !hold_served) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_served = 1'b1;
            rsp_tready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (sink_idle && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 8) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      logic [31:0]      key_pool [24];
      logic [CAP_W-1:0] phase_capacity [PHASES];
      logic [CAP_W-1:0] cap;
      logic             op;
      logic [31:0]      k;
      int               n_keys;

      // 0 acts as 1 and 31 acts as ENTRIES; phase 5 draws its own
      phase_capacity = '{5'd16, 5'd0, 5'd1, 5'd31, 5'd4, 5'd9, 5'd16};

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed: empty store, extreme keys and values ----
      send_item(FUNC_GET, 32'h0000_0000, 32'h0000_0000);   // miss on empty cache
      send_item(FUNC_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      send_item(FUNC_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_item(FUNC_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);   // stored -1 must still hit
      send_item(FUNC_PUT, 32'h0000_0000, 32'h0000_0000);
      send_item(FUNC_GET, 32'h8000_0000, 32'h0000_0000);
      send_item(FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000);
      send_item(FUNC_GET, 32'h1234_5678, 32'hFFFF_FFFF);   // miss among used slots
      send_item(FUNC_PUT, 32'h7FFF_FFFF, 32'h5555_AAAA);   // update in place
      send_item(FUNC_GET, 32'h7FFF_FFFF, 32'h0000_0000);
      // fill all 16 slots, then one more new key evicts the oldest (key 0)
      for (int i = 0; i < 12; i++)
         send_item(FUNC_PUT, 32'd100 + i, $urandom);
      send_item(FUNC_PUT, 32'd200, 32'hA5A5_A5A5);
      send_item(FUNC_GET, 32'h0000_0000, 32'h0000_0000);

      // capacity dropped under the fill: a new key evicts only one entry
      set_capacity(5'd3);
      send_item(FUNC_PUT, 32'd300, 32'h0F0F_0F0F);
      send_item(FUNC_GET, 32'd300, 32'h0000_0000);
      send_item(FUNC_GET, 32'd200, 32'h0000_0000);
      send_item(FUNC_GET, 32'h8000_0000, 32'h0000_0000);

      // ---- random phases ----
      for (int phase = 0; phase < PHASES; phase++) begin
         cap = (phase == 5) ? CAP_W'($urandom_range(2, 15)) : phase_capacity[phase];
         set_capacity(cap);

         // phase 3 runs without gaps, the last phase too
         source_idle = (phase != 3 && phase != PHASES - 1);
         sink_idle   = source_idle;
         // phase 1: hold responses off long enough to back up the request side
         if (phase == 1)
            long_hold = 1'b1;

         // key pool a little larger than the usable capacity keeps hits and evictions
         n_keys = (cap == 0) ? 1 : ((cap > ENTRIES) ? ENTRIES : cap);
         n_keys = n_keys + 4;
         for (int i = 0; i < 24; i++)
            key_pool[i] = $urandom;
         key_pool[0] = 32'h8000_0000;
         key_pool[1] = 32'h7FFF_FFFF;

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 1)
               op = ($urandom_range(0, 3) != 0) ? FUNC_GET : FUNC_PUT;
            else
               op = ($urandom_range(0, 1) == 0) ? FUNC_GET : FUNC_PUT;
            k = ($urandom_range(0, 6) == 0) ? $urandom : key_pool[$urandom_range(0, n_keys - 1)];
            send_item(op, k, $urandom);
         end
      end

      wait_until_idle();
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // hard stop in case the handshakes hang
   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("FAIL");
      $finish;
   end

endmodule
